[design/itf_pkg.sv]
// itf_pkg: transaction types, codes, controller states and command/status
// structs for the integer to text formatter. No dependencies.
package itf_pkg;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  char_in;
      logic [63:0] value;
      logic [2:0]  conv;
      logic [1:0]  size_sel;
      logic [5:0]  width;
      logic [1:0]  align;
      logic        space_flag;
      logic        alt_flag;
      logic        zero_pad;
   } itf_req_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic [15:0] position;
      logic [15:0] count;
      logic        last;
   } itf_rsp_type;

   localparam logic [1:0] KIND_LIT  = 2'd0;
   localparam logic [1:0] KIND_CONV = 2'd1;
   localparam logic [1:0] KIND_FIN  = 2'd2;

   localparam logic [2:0] CONV_SDEC = 3'd0;
   localparam logic [2:0] CONV_UDEC = 3'd1;
   localparam logic [2:0] CONV_OCT  = 3'd2;
   localparam logic [2:0] CONV_HEX  = 3'd3;
   localparam logic [2:0] CONV_UHEX = 3'd4;
   localparam logic [2:0] CONV_PTR  = 3'd5;

   localparam logic [1:0] SIZE_32 = 2'd0;
   localparam logic [1:0] SIZE_64 = 2'd1;
   localparam logic [1:0] SIZE_16 = 2'd2;
   localparam logic [1:0] SIZE_8  = 2'd3;

   localparam logic [1:0] ALIGN_PLUS = 2'd1;
   localparam logic [1:0] ALIGN_LEFT = 2'd2;

   localparam logic [15:0] LIMIT_RESET  = 16'd255;
   localparam logic [6:0]  DABBLE_STEPS = 7'd64;
   localparam int          BCD_DIGITS   = 20;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOWA  = 8'h61;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_TEN   = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_LOWX  = 8'h78;
   localparam logic [7:0] CH_UPX   = 8'h58;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LIT, ST_FIN, ST_DABBLE, ST_MEASURE, ST_ROUTE,
      ST_PRE, ST_PLUS, ST_SPACE, ST_MINUS, ST_PFX0, ST_PFXX, ST_BODY, ST_POST
   } itf_state_type;

   typedef struct packed {
      logic          load;
      logic          dabble;
      logic          measure;
      logic          emit;
      itf_state_type phase;
   } itf_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic room;
      logic stop;
      logic dabble_done;
      logic pad_nz;
      logic pad_last;
      logic dig_last;
      logic flush_left;
      logic need_plus;
      logic need_space;
      logic need_minus;
      logic need_pfx0;
      logic need_pfxx;
   } itf_status_type;

endpackage

[design/integer_to_text_formatter.sv]
// integer_to_text_formatter: top level joining itf_ctrl and itf_datapath.
// Depends on itf_pkg, itf_ctrl, itf_datapath.
//
//   channel  direction  handshake        payload
//   req_     in         valid / stall    itf_req_type
//   rsp_     out        valid / stall    itf_rsp_type
//   csr_     in         write enable     buffer_limit, 16 bits
//
// literal and finish: LIT or FIN state; hex, octal, pointer: MEASURE and
// ROUTE, then the characters in turn; decimal adds the shift-add-3 state.
// one transaction at a time; the result register holds under rsp_stall.
// reset clears the count and sets the limit to 255; no clearing pass.
module integer_to_text_formatter import itf_pkg::*; #(
   parameter int MAX_WIDTH  = 62,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  itf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output itf_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   itf_cmd_type    cmd;
   itf_status_type status;

   itf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_conv  (req_data.conv),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_accept_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || rsp_data.last))
      else $error("transaction accepted before previous results ended");

   a_busy_mid_string: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |-> req_stall)
      else $error("input open while results still pending");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.count == rsp_data.position + 16'd1) ||
                     (rsp_data.last && rsp_data.count == rsp_data.position)))
      else $error("result count inconsistent with position");
`endif

endmodule

[design/itf_ctrl.sv]
// itf_ctrl: sequencer for literal, finish and conversion transactions.
// Depends on itf_pkg; drives commands into itf_datapath.
module itf_ctrl import itf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_kind,
   input  logic [2:0]     req_conv,
   output logic           req_stall,
   input  itf_status_type status,
   output itf_cmd_type    cmd
);

   itf_state_type state_ff, state_in;

   function automatic itf_state_type after(itf_state_type s, itf_status_type st);
      itf_state_type r;
      r = ST_IDLE;
      if (s < ST_PRE && st.pad_nz && !st.flush_left) r = ST_PRE;
      else if (s < ST_PLUS && st.need_plus) r = ST_PLUS;
      else if (s < ST_SPACE && st.need_space) r = ST_SPACE;
      else if (s < ST_MINUS && st.need_minus) r = ST_MINUS;
      else if (s < ST_PFX0 && st.need_pfx0) r = ST_PFX0;
      else if (s < ST_PFXX && st.need_pfxx) r = ST_PFXX;
      else if (s < ST_BODY) r = ST_BODY;
      else if (s < ST_POST && st.pad_nz && st.flush_left) r = ST_POST;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_LIT: state_in = ST_LIT;
                  KIND_FIN: state_in = ST_FIN;
                  KIND_CONV: begin
                     if (req_conv inside {CONV_SDEC, CONV_UDEC}) state_in = ST_DABBLE;
                     else if (req_conv <= CONV_PTR) state_in = ST_MEASURE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LIT, ST_FIN: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         ST_DABBLE: begin
            if (status.dabble_done) state_in = ST_MEASURE;
         end
         ST_MEASURE: state_in = ST_ROUTE;
         ST_ROUTE: state_in = status.room ? after(ST_ROUTE, status) : ST_IDLE;
         ST_PRE, ST_PLUS, ST_SPACE, ST_MINUS, ST_PFX0, ST_PFXX, ST_BODY, ST_POST: begin
            if (status.slot_free) begin
               if (!status.room || status.stop) state_in = ST_IDLE;
               else if ((state_ff inside {ST_PRE, ST_POST}) && !status.pad_last)
                  state_in = state_ff;
               else if (state_ff == ST_BODY && !status.dig_last) state_in = state_ff;
               else state_in = after(state_ff, status);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      cmd.load    = req_valid && (state_ff == ST_IDLE);
      cmd.dabble  = (state_ff == ST_DABBLE);
      cmd.measure = (state_ff == ST_MEASURE);
      cmd.phase   = state_ff;
      case (state_ff)
         ST_FIN: cmd.emit = status.slot_free;
         ST_LIT, ST_PRE, ST_PLUS, ST_SPACE, ST_MINUS, ST_PFX0, ST_PFXX, ST_BODY,
         ST_POST: cmd.emit = status.slot_free && status.room;
         default: cmd.emit = 1'b0;
      endcase
   end

endmodule

[design/itf_datapath.sv]
// itf_datapath: capture, double-dabble decimal unit, length measure,
// character select, counters and output register. Depends on itf_pkg.
module itf_datapath import itf_pkg::*; #(
   parameter int MAX_WIDTH  = 62,
   parameter int COUNT_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  itf_req_type    req_data,
   input  logic           csr_we,
   input  logic [15:0]    csr_wdata,
   input  itf_cmd_type    cmd,
   output itf_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output itf_rsp_type    rsp_data
);

   localparam int CW = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 1;
   localparam int BW = BCD_DIGITS * 4;

   logic [15:0]           limit_ff, limit_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   itf_rsp_type           rsp_data_ff, rsp_data_in;
   logic [7:0]            char_ff, char_in;
   logic [2:0]            conv_ff, conv_in;
   logic [1:0]            align_ff, align_in;
   logic                  space_ff, space_in, alt_ff, alt_in, zero_ff, zero_in;
   logic [5:0]            width_ff, width_in;
   logic [63:0]           mag_ff, mag_in, shift_ff, shift_in;
   logic                  neg_ff, neg_in, pos_ff, pos_in, nil_ff, nil_in;
   logic [BW-1:0]         bcd_ff, bcd_in;
   logic [6:0]            step_ff, step_in;
   logic [5:0]            pad_ff, pad_in;
   logic [4:0]            idx_ff, idx_in;
   logic [6:0]            rem_ff, rem_in;

   logic [63:0]   nar;
   logic          dec, upper;
   logic [BW-1:0] adj;
   logic [4:0]    nd_hex, nd_oct, nd_dec, nd;
   logic [65:0]   mag66;
   logic [87:0]   bcd88, mag88;
   logic [4:0]    len;
   logic [5:0]    padn;
   logic [4:0]    body;
   logic [3:0]    dval;
   logic [7:0]    ch, dch;
   logic [CW-1:0] cnt_ext, lim_ext, max_ext, nxt_ext;
   logic          room_next;

   assign dec   = conv_ff inside {CONV_SDEC, CONV_UDEC};
   assign upper = (conv_ff == CONV_UHEX);
   assign mag66 = {2'b00, mag_ff};
   assign bcd88 = {8'd0, bcd_ff};
   assign mag88 = {24'd0, mag_ff};

   // narrowing and sign handling at capture
   always_comb begin
      case (req_data.size_sel)
         SIZE_32: nar = (req_data.conv == CONV_SDEC) ?
                        {{32{req_data.value[31]}}, req_data.value[31:0]} :
                        {32'd0, req_data.value[31:0]};
         SIZE_16: nar = (req_data.conv == CONV_SDEC) ?
                        {{48{req_data.value[15]}}, req_data.value[15:0]} :
                        {48'd0, req_data.value[15:0]};
         SIZE_8:  nar = (req_data.conv == CONV_SDEC) ?
                        {{56{req_data.value[7]}}, req_data.value[7:0]} :
                        {56'd0, req_data.value[7:0]};
         default: nar = req_data.value;
      endcase
      if (req_data.conv == CONV_PTR) nar = req_data.value;
   end

   // double-dabble step
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3 :
                         bcd_ff[4*i +: 4];
      end
   end

   // digit counts per base
   always_comb begin
      nd_hex = 5'd1;
      nd_oct = 5'd1;
      nd_dec = 5'd1;
      for (int i = 0; i < 16; i++) begin
         if (mag_ff[4*i +: 4] != 4'd0) nd_hex = 5'(i + 1);
      end
      for (int i = 0; i < 22; i++) begin
         if (mag66[3*i +: 3] != 3'd0) nd_oct = 5'(i + 1);
      end
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) nd_dec = 5'(i + 1);
      end
      if (dec) nd = nd_dec;
      else if (conv_ff == CONV_OCT) nd = nd_oct;
      else nd = nd_hex;
      len  = nil_ff ? 5'd5 : nd + {4'd0, neg_ff};
      padn = (width_ff > {1'b0, len}) ? width_ff - {1'b0, len} : 6'd0;
      body = nil_ff ? 5'd5 : nd;
   end

   // status
   always_comb begin
      cnt_ext   = CW'(count_ff);
      lim_ext   = CW'(limit_ff);
      max_ext   = CW'({COUNT_BITS{1'b1}});
      nxt_ext   = cnt_ext + CW'(1);
      room_next = (nxt_ext < lim_ext) && (nxt_ext < max_ext);
      status.slot_free   = !rsp_valid_ff || !rsp_stall;
      status.room        = (cnt_ext < lim_ext) && (cnt_ext < max_ext);
      status.stop        = (rem_ff == 7'd1) || !room_next;
      status.dabble_done = (step_ff == 7'd0);
      status.pad_nz      = (pad_ff != 6'd0);
      status.pad_last    = (pad_ff == 6'd1);
      status.dig_last    = (idx_ff == 5'd0);
      status.flush_left  = (align_ff == ALIGN_LEFT);
      status.need_plus   = dec && pos_ff && (align_ff == ALIGN_PLUS);
      status.need_space  = dec && pos_ff && space_ff;
      status.need_minus  = neg_ff;
      status.need_pfx0   = !dec && !nil_ff && (alt_ff || conv_ff == CONV_PTR);
      status.need_pfxx   = status.need_pfx0 && (conv_ff != CONV_OCT);
   end

   // character select
   always_comb begin
      if (dec) dval = bcd88[4*idx_ff +: 4];
      else if (conv_ff == CONV_OCT) dval = {1'b0, mag66[3*idx_ff +: 3]};
      else dval = mag88[4*idx_ff +: 4];
      dch = (dval < 4'd10) ? CH_ZERO + {4'd0, dval} :
            (upper ? CH_UPA : CH_LOWA) + {4'd0, dval} - CH_TEN;
      case (cmd.phase)
         ST_LIT:           ch = char_ff;
         ST_PRE, ST_POST:  ch = zero_ff ? CH_ZERO : CH_SPACE;
         ST_PLUS:          ch = CH_PLUS;
         ST_SPACE:         ch = CH_SPACE;
         ST_MINUS:         ch = CH_MINUS;
         ST_PFX0:          ch = CH_ZERO;
         ST_PFXX:          ch = upper ? CH_UPX : CH_LOWX;
         ST_BODY: begin
            if (nil_ff) begin
               case (idx_ff)
                  5'd4:    ch = CH_LPAR;
                  5'd3:    ch = CH_N;
                  5'd2:    ch = CH_I;
                  5'd1:    ch = CH_L;
                  default: ch = CH_RPAR;
               endcase
            end else begin
               ch = dch;
            end
         end
         default:          ch = CH_NUL;
      endcase
   end

   // next values
   always_comb begin
      limit_in = csr_we ? csr_wdata : limit_ff;
      char_in  = char_ff;
      conv_in  = conv_ff;
      align_in = align_ff;
      space_in = space_ff;
      alt_in   = alt_ff;
      zero_in  = zero_ff;
      width_in = width_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      pos_in   = pos_ff;
      nil_in   = nil_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      pad_in   = pad_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         char_in  = req_data.char_in;
         conv_in  = req_data.conv;
         align_in = req_data.align;
         space_in = req_data.space_flag;
         alt_in   = req_data.alt_flag;
         zero_in  = req_data.zero_pad;
         width_in = (32'(req_data.width) > MAX_WIDTH) ? 6'(MAX_WIDTH) : req_data.width;
         neg_in   = (req_data.conv == CONV_SDEC) && nar[63];
         mag_in   = neg_in ? ~nar + 64'd1 : nar;
         pos_in   = (nar != 64'd0) && !nar[63];
         nil_in   = (req_data.conv == CONV_PTR) && (nar == 64'd0);
         shift_in = mag_in;
         bcd_in   = '0;
         step_in  = DABBLE_STEPS;
      end
      if (cmd.dabble && step_ff != 7'd0) begin
         bcd_in   = {adj[BW-2:0], shift_ff[63]};
         shift_in = {shift_ff[62:0], 1'b0};
         step_in  = step_ff - 7'd1;
      end
      if (cmd.measure) begin
         pad_in = padn;
         idx_in = nil_ff ? 5'd4 : nd - 5'd1;
         rem_in = {1'b0, padn} + {6'd0, status.need_plus} + {6'd0, status.need_space}
                + {6'd0, status.need_minus} + {6'd0, status.need_pfx0}
                + {6'd0, status.need_pfxx} + {2'd0, body};
      end

      if (status.slot_free) rsp_valid_in = cmd.emit;
      if (cmd.emit) begin
         rsp_data_in.out_char = ch;
         rsp_data_in.position = 16'(count_ff);
         if (cmd.phase == ST_FIN) begin
            rsp_data_in.count = 16'(count_ff);
            rsp_data_in.last  = 1'b1;
            count_in          = '0;
         end else begin
            rsp_data_in.count = 16'(count_ff + 1'b1);
            rsp_data_in.last  = (cmd.phase == ST_LIT) || status.stop;
            count_in          = count_ff + 1'b1;
         end
         rem_in = rem_ff - 7'd1;
         if (cmd.phase inside {ST_PRE, ST_POST}) pad_in = pad_ff - 6'd1;
         if (cmd.phase == ST_BODY) idx_in = idx_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      char_ff     <= char_in;
      conv_ff     <= conv_in;
      align_ff    <= align_in;
      space_ff    <= space_in;
      alt_ff      <= alt_in;
      zero_ff     <= zero_in;
      width_ff    <= width_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      nil_ff      <= nil_in;
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      pad_ff      <= pad_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/integer_to_text_formatter_tb.sv]
// integer_to_text_formatter_tb: self-checking testbench for the integer to text formatter.
// Predicts every character from its own model of the formatter and compares each response.
// Depends on itf_pkg and integer_to_text_formatter.
`timescale 1ns / 1ps

module integer_to_text_formatter_tb;
   import itf_pkg::*;

   localparam int         MAX_W     = 62;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [2:0] CONV_BAD6 = 3'd6;
   localparam logic [2:0] CONV_BAD7 = 3'd7;
   localparam logic [1:0] ALIGN_DEF = 2'd0;
   localparam logic [1:0] ALIGN_ODD = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   itf_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   itf_rsp_type rsp_data;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   integer_to_text_formatter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   itf_req_type pending_items[$];
   itf_rsp_type expected_chars[$];
   int          errors = 0;
   int          cycles = 0;
   logic [15:0] model_count;
   logic [15:0] model_limit;
   logic [7:0]  digits[0:23];
   int          hold_off = 0;
   int          rsp_wait = 0;
   int          req_wait = 0;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   task automatic push_char(logic [7:0] c);
      itf_rsp_type r;
      if (model_count < model_limit) begin
         r.out_char = c;
         r.position = model_count;
         model_count++;
         r.count = model_count;
         r.last = 1'b0;
         expected_chars.push_back(r);
      end
   endtask

   function automatic int make_digit_text(logic [63:0] n, int base, bit upper);
      int len;
      int r;
      len = 0;
      do begin
         r = int'(n % 64'(base));
         digits[len] = r < 10 ? 8'(CH_ZERO + r) : 8'((upper ? CH_UPA : CH_LOWA) - CH_TEN + r);
         len++;
         n = n / 64'(base);
      end while (n != 0 && len < 23);
      return len;
   endfunction

   task automatic format_number(itf_req_type it);
      logic [63:0] v, m, top, mag;
      int w, ndig, len, padn, i;
      bit neg, pos, nil, alt;
      logic [7:0] pc;
      neg = 1'b0; nil = 1'b0; ndig = 0;
      alt = it.alt_flag;
      pc = it.zero_pad ? CH_ZERO : CH_SPACE;
      w = int'(it.width) > MAX_W ? MAX_W : int'(it.width);
      if (it.conv == CONV_PTR) begin
         v = it.value; alt = 1'b1; nil = (v == 64'd0);
      end else begin
         v = it.value;
         if (it.size_sel != SIZE_64) begin
            case (it.size_sel)
               SIZE_32: begin m = 64'hFFFF_FFFF; top = 64'h8000_0000; end
               SIZE_16: begin m = 64'hFFFF; top = 64'h8000; end
               default: begin m = 64'hFF; top = 64'h80; end
            endcase
            v = v & m;
            if (it.conv == CONV_SDEC && (v & top) != 64'd0) v = v | ~m;
         end
      end
      pos = v != 64'd0 && !v[63];
      if (nil) len = 5;
      else if (it.conv <= CONV_UDEC) begin
         mag = v;
         if (it.conv == CONV_SDEC && v[63]) begin
            neg = 1'b1; mag = ~v + 64'd1;
         end
         ndig = make_digit_text(mag, 10, 1'b0);
         len = ndig + int'(neg);
      end else begin
         ndig = make_digit_text(v, it.conv == CONV_OCT ? 8 : 16, it.conv == CONV_UHEX);
         len = ndig;
      end
      padn = w > len ? w - len : 0;
      if (it.align != ALIGN_LEFT) for (i = 0; i < padn; i++) push_char(pc);
      if (nil) begin
         push_char(CH_LPAR); push_char(CH_N); push_char(CH_I);
         push_char(CH_L); push_char(CH_RPAR);
      end else begin
         if (it.conv <= CONV_UDEC) begin
            if (pos && it.align == ALIGN_PLUS) push_char(CH_PLUS);
            if (it.space_flag && pos) push_char(CH_SPACE);
            if (neg) push_char(CH_MINUS);
         end else if (alt) begin
            push_char(CH_ZERO);
            if (it.conv != CONV_OCT) push_char(it.conv == CONV_UHEX ? CH_UPX : CH_LOWX);
         end
         for (i = ndig; i > 0; i--) push_char(digits[i-1]);
      end
      if (it.align == ALIGN_LEFT) for (i = 0; i < padn; i++) push_char(pc);
   endtask

   task automatic predict_item(itf_req_type it);
      int prior_size;
      itf_rsp_type r;
      prior_size = expected_chars.size();
      if (it.kind == KIND_LIT) push_char(it.char_in);
      else if (it.kind == KIND_CONV) begin
         if (it.conv <= CONV_PTR) format_number(it);
      end else if (it.kind == KIND_FIN) begin
         r.out_char = CH_NUL; r.position = model_count; r.count = model_count;
         r.last = 1'b0;
         expected_chars.push_back(r);
         model_count = '0;
      end
      if (expected_chars.size() > prior_size) begin
         r = expected_chars[$];
         r.last = 1'b1;
         expected_chars[$] = r;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_item(req_data);
         req_wait = $urandom_range(0, 6);
         if (req_wait == 0 && pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid && pending_items.size() > 0) begin
         if (req_wait > 0) req_wait--;
         else begin
            req_valid <= 1'b1;
            req_data <= pending_items.pop_front();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      itf_rsp_type e;
      cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report("unexpected", 64'(rsp_data), 64'd0);
         end else begin
            e = expected_chars.pop_front();
            if (rsp_data.out_char !== e.out_char)
               report("out_char", 64'(rsp_data.out_char), 64'(e.out_char));
            if (rsp_data.position !== e.position)
               report("position", 64'(rsp_data.position), 64'(e.position));
            if (rsp_data.count !== e.count)
               report("count", 64'(rsp_data.count), 64'(e.count));
            if (rsp_data.last !== e.last)
               report("last", 64'(rsp_data.last), 64'(e.last));
         end
         rsp_wait = $urandom_range(0, 6);
      end
      if (hold_off > 0) begin
         hold_off--;
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0 && ($urandom_range(0, 3) != 0)) begin
         rsp_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_wait = 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (cycles > 2000000) begin
         $display("integer_to_text_formatter regression: fail");
         $finish;
      end
   end

   function automatic itf_req_type rand_item();
      itf_req_type it;
      int k;
      it = '0;
      k = $urandom_range(0, 19);
      it.kind = k < 6 ? KIND_LIT : (k < 17 ? KIND_CONV : (k < 19 ? KIND_FIN : KIND_NONE));
      it.char_in = 8'($urandom);
      it.value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: it.value = 64'($urandom_range(0, 20));
         1: it.value = -64'($urandom_range(1, 20));
         default: ;
      endcase
      if ($urandom_range(0, 12) == 0)
         it.conv = ($urandom_range(0, 1) == 0) ? CONV_BAD6 : CONV_BAD7;
      else
         it.conv = 3'($urandom_range(0, 5));
      it.size_sel = 2'($urandom);
      it.width = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 12));
      it.align = 2'($urandom);
      it.space_flag = 1'($urandom);
      it.alt_flag = 1'($urandom);
      it.zero_pad = 1'($urandom);
      return it;
   endfunction

   function automatic itf_req_type conv_item(logic [2:0] c, logic [63:0] v, logic [1:0] sz,
                                             logic [5:0] w, logic [1:0] al, bit sp, bit alt, bit z);
      itf_req_type it;
      it = '0;
      it.kind = KIND_CONV; it.conv = c; it.value = v; it.size_sel = sz; it.width = w;
      it.align = al; it.space_flag = sp; it.alt_flag = alt; it.zero_pad = z;
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_chars.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_limit(logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      model_limit = v;
   endtask

   initial begin
      itf_req_type it;
      int i, phase;
      logic [15:0] limits[0:3];
      model_count = '0;
      model_limit = LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      it = '0; it.kind = KIND_LIT; it.char_in = 8'hFF; pending_items.push_back(it);
      it.char_in = 8'h00; pending_items.push_back(it);
      pending_items.push_back(conv_item(CONV_SDEC, 64'h8000_0000_0000_0000, SIZE_64, 6'd0,
                                        ALIGN_DEF, 1'b0, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, SIZE_64, 6'd30,
                                        ALIGN_PLUS, 1'b1, 1'b0, 1'b1));
      pending_items.push_back(conv_item(CONV_SDEC, 64'h80, SIZE_8, 6'd8,
                                        ALIGN_DEF, 1'b0, 1'b0, 1'b1));
      pending_items.push_back(conv_item(CONV_SDEC, 64'hFFFF_8000, SIZE_16, 6'd9,
                                        ALIGN_LEFT, 1'b0, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_UDEC, '1, SIZE_64, 6'd63,
                                        ALIGN_DEF, 1'b1, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_UDEC, '1, SIZE_32, 6'd0,
                                        ALIGN_ODD, 1'b1, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_OCT, '1, SIZE_64, 6'd0,
                                        ALIGN_DEF, 1'b0, 1'b1, 1'b0));
      pending_items.push_back(conv_item(CONV_OCT, 64'd0, SIZE_64, 6'd0,
                                        ALIGN_DEF, 1'b0, 1'b1, 1'b0));
      pending_items.push_back(conv_item(CONV_HEX, 64'hDEAD_BEEF_CAFE, SIZE_64, 6'd20,
                                        ALIGN_LEFT, 1'b0, 1'b1, 1'b1));
      pending_items.push_back(conv_item(CONV_UHEX, 64'hABCDEF, SIZE_16, 6'd6,
                                        ALIGN_DEF, 1'b0, 1'b1, 1'b0));
      pending_items.push_back(conv_item(CONV_PTR, 64'd0, SIZE_8, 6'd10,
                                        ALIGN_LEFT, 1'b0, 1'b0, 1'b1));
      pending_items.push_back(conv_item(CONV_PTR, 64'h1234, SIZE_8, 6'd12,
                                        ALIGN_DEF, 1'b0, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_UDEC, 64'd0, SIZE_64, 6'd1,
                                        ALIGN_PLUS, 1'b1, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_BAD6, 64'd5, SIZE_64, 6'd4,
                                        ALIGN_DEF, 1'b0, 1'b0, 1'b0));
      pending_items.push_back(conv_item(CONV_BAD7, 64'd5, SIZE_64, 6'd4,
                                        ALIGN_DEF, 1'b0, 1'b0, 1'b0));
      it = '0; it.kind = KIND_NONE; pending_items.push_back(it);
      it.kind = KIND_FIN; pending_items.push_back(it);
      pending_items.push_back(it);
      wait_drained();

      limits[0] = 16'd0; limits[1] = 16'd7; limits[2] = 16'hFFFF; limits[3] = 16'd40;
      for (phase = 0; phase < 4; phase++) begin
         set_limit(limits[phase]);
         for (i = 0; i < 40; i++) pending_items.push_back(rand_item());
         if (phase == 2) begin
            // long receiver hold-off while items keep coming
            @(posedge clock);
            hold_off = 400;
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("integer_to_text_formatter regression: pass");
      end else begin
         $display("integer_to_text_formatter regression: fail");
      end
      $finish;
   end

endmodule
